// ===== rtl/core/smm_pkg.sv =====
// Shared types and constants for the square matrix multiplier.
`default_nettype none

package smm_pkg;

   localparam int ELEM_W = 16;
   localparam int IDX_W  = 2;

   typedef logic [ELEM_W-1:0] elem_type;
   typedef logic [IDX_W-1:0]  idx_type;

   typedef struct packed {
      logic    first_k;
      logic    last_k;
      idx_type row;
      idx_type col;
      logic    last_elem;
   } tag_type;

endpackage

`default_nettype wire

// ===== rtl/core/square_matrix_multiply.sv =====
// Square matrix multiplier: two element stores and a multiply-accumulate pipeline.
//
// Usage: load matrix elements one word at a time on the req_ ports; a word is
// taken at a rising edge with start high and busy low. req_which_matrix picks
// the left (0) or right (1) store, req_row and req_col the entry; a word whose
// row or column is DIM or more writes nothing. A word with req_go set is
// written like any other and then starts the multiply: busy rises and the
// block walks i, j, k, reading one entry of each store per cycle, through a
// pipeline of store read, multiply and accumulate. The DIM*DIM product words
// leave row-major on the rsp_ ports, each for one cycle with rsp_strobe high,
// one at the end of each walk over k; rsp_last marks the final one. busy falls
// in the cycle that final word is presented, so the next load may follow
// directly. The receiver cannot stall: every word is taken in the cycle it is
// shown. Reset clears busy, the issue flag, the pipeline valid bits and
// rsp_strobe; the stores are not cleared and an entry must be written before
// a multiply reads it.
`default_nettype none

module square_matrix_multiply #(
   parameter int DIM = 4
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire                 req_which_matrix,
   input  wire smm_pkg::idx_type  req_row,
   input  wire smm_pkg::idx_type  req_col,
   input  wire smm_pkg::elem_type req_element_value,
   input  wire                 req_go,
   output logic                rsp_strobe,
   output smm_pkg::idx_type    rsp_out_row,
   output smm_pkg::idx_type    rsp_out_col,
   output smm_pkg::elem_type   rsp_product_value,
   output logic                rsp_last
);

   localparam int CELLS = DIM * DIM;
   localparam int IW    = $clog2(DIM);
   localparam int AW    = $clog2(CELLS);

   smm_pkg::elem_type left_mem  [CELLS];
   smm_pkg::elem_type right_mem [CELLS];

   logic              busy_ff, busy_in;
   logic              issue_ff, issue_in;
   logic [IW-1:0]     i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic              rd_v_ff;
   smm_pkg::tag_type  rd_tag_ff;
   smm_pkg::elem_type rd_a_ff, rd_b_ff;
   logic              mul_v_ff;
   smm_pkg::tag_type  mul_tag_ff;
   smm_pkg::elem_type prod_ff;
   smm_pkg::elem_type acc_ff, acc_in;
   logic              rsp_strobe_ff;
   smm_pkg::idx_type  rsp_row_ff, rsp_col_ff;
   smm_pkg::elem_type rsp_value_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              in_range;
   logic [AW-1:0]     wr_addr, rd_a_addr, rd_b_addr;
   logic              k_end, j_end, i_end;
   smm_pkg::tag_type  issue_tag;
   smm_pkg::elem_type sum;

   assign accept   = start && !busy_ff;
   assign in_range = (32'(req_row) < DIM) && (32'(req_col) < DIM);
   assign wr_addr  = AW'(32'(req_row) * DIM + 32'(req_col));
   assign rd_a_addr = AW'(32'(i_ff) * DIM + 32'(k_ff));
   assign rd_b_addr = AW'(32'(k_ff) * DIM + 32'(j_ff));

   assign k_end = (k_ff == IW'(DIM - 1));
   assign j_end = (j_ff == IW'(DIM - 1));
   assign i_end = (i_ff == IW'(DIM - 1));

   assign issue_tag.first_k   = (k_ff == '0);
   assign issue_tag.last_k    = k_end;
   assign issue_tag.row       = smm_pkg::IDX_W'(i_ff);
   assign issue_tag.col       = smm_pkg::IDX_W'(j_ff);
   assign issue_tag.last_elem = i_end && j_end;

   assign sum = (mul_tag_ff.first_k ? '0 : acc_ff) + prod_ff;

   // advance i, j, k through the run
   always_comb begin
      issue_in = issue_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      busy_in  = busy_ff;
      acc_in   = acc_ff;
      if (accept && req_go) begin
         issue_in = 1'b1;
         busy_in  = 1'b1;
         i_in     = '0;
         j_in     = '0;
         k_in     = '0;
      end else if (issue_ff) begin
         if (k_end) begin
            k_in = '0;
            if (j_end) begin
               j_in = '0;
               if (i_end) begin
                  issue_in = 1'b0;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
      if (mul_v_ff) begin
         acc_in = sum;
         if (mul_tag_ff.last_k && mul_tag_ff.last_elem) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_range) begin
         if (req_which_matrix) begin
            right_mem[wr_addr] <= req_element_value;
         end else begin
            left_mem[wr_addr] <= req_element_value;
         end
      end
      if (issue_ff) begin
         rd_a_ff <= left_mem[rd_a_addr];
         rd_b_ff <= right_mem[rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         issue_ff      <= 1'b0;
         rd_v_ff       <= 1'b0;
         mul_v_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         issue_ff      <= issue_in;
         rd_v_ff       <= issue_ff;
         mul_v_ff      <= rd_v_ff;
         rsp_strobe_ff <= mul_v_ff && mul_tag_ff.last_k;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      rd_tag_ff  <= issue_tag;
      mul_tag_ff <= rd_tag_ff;
      prod_ff    <= smm_pkg::ELEM_W'(rd_a_ff * rd_b_ff);
      acc_ff     <= acc_in;
      if (mul_v_ff && mul_tag_ff.last_k) begin
         rsp_row_ff   <= mul_tag_ff.row;
         rsp_col_ff   <= mul_tag_ff.col;
         rsp_value_ff <= sum;
         rsp_last_ff  <= mul_tag_ff.last_elem;
      end
   end

   assign busy              = busy_ff;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire
